FILE: rtl/lkv_pkg.sv
// Shared types and constants for the LRU key/value cache.
// No dependencies; imported by the cell and the top level.
package lkv_pkg;

  localparam int CAP_W = 5;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int MAX_ENTRIES_DEF = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_MOVE
  } fsm_state_t;

  typedef enum logic {
    MODE_SEARCH,
    MODE_WRITE
  } wave_mode_t;

  typedef struct packed {
    logic             command;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } out_rsp_t;

  // Request token that walks the chain one cell per cycle.
  typedef struct packed {
    logic             active;
    wave_mode_t       mode;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] carry_key;
    logic [VAL_W-1:0] carry_val;
    logic             done;
    logic             hit;
    logic [VAL_W-1:0] rd;
    logic             ev;
    logic [KEY_W-1:0] evk;
  } wave_t;

endpackage

FILE: rtl/lkv_cell.sv
// One entry of the recency-ordered chain: holds a key, a value and a valid bit.
// Depends on lkv_pkg for the request token type.
module lkv_cell
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int INDEX       = 0,
  localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic [IDX_W-1:0] last_idx,
  input  wave_t            wave_in,
  output wave_t            wave_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  wave_t            wave_r, wave_nxt;
  logic             match;
  logic             is_last;

  assign match   = valid_r && (key_r == wave_in.key);
  assign is_last = (MY_IDX == last_idx);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    wave_nxt  = wave_in;
    if (wave_in.active && !wave_in.done) begin
      case (wave_in.mode)
        MODE_SEARCH: begin
          if (match) begin
            wave_nxt.hit  = 1'b1;
            wave_nxt.rd   = val_r;
            wave_nxt.done = 1'b1;
          end
        end
        MODE_WRITE: begin
          // take the carried entry; hand ours on unless the walk ends here
          valid_nxt = 1'b1;
          key_nxt   = wave_in.carry_key;
          val_nxt   = wave_in.carry_val;
          if (match) begin
            wave_nxt.hit  = 1'b1;
            wave_nxt.done = 1'b1;
          end else if (!valid_r) begin
            wave_nxt.done = 1'b1;
          end else if (is_last) begin
            wave_nxt.ev   = 1'b1;
            wave_nxt.evk  = key_r;
            wave_nxt.done = 1'b1;
          end else begin
            wave_nxt.carry_key = key_r;
            wave_nxt.carry_val = val_r;
          end
        end
        default: begin
          wave_nxt = wave_in;
        end
      endcase
    end
    if (clear) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      wave_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      wave_r  <= wave_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

  assign wave_out = wave_r;

endmodule

FILE: rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key/value cache.
// Depends on lkv_pkg and builds the row of lkv_cell entries.
//
// Entries sit in a chain of cells ordered by recency: cell 0 holds the most
// recent entry and the last cell in use holds the least recent one. A request
// is a token that walks the chain one cell per clock. A put shifts entries
// down behind it until it meets its own key, a free cell or the last cell in
// use (where the least recent entry falls out and is reported). A get first
// walks read-only to find its key; on a hit a second walk moves the entry to
// the front. The block takes a request at a clock edge with start high and
// busy low; the result appears on out_data for one cycle with out_valid high,
// and the receiver cannot stall it. The block stays busy and takes no new
// request until the token has walked the whole chain, once for a put or a
// missing get and twice for a get hit; the result is given after the first
// walk. A capacity write (cfg_valid with cfg_ready, taken while idle) clears
// every entry at once; a value of zero acts as one and values above
// MAX_ENTRIES saturate.
module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_req_t          in_req,
  output logic             out_valid,
  output out_rsp_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  fsm_state_t       state_r, state_nxt;
  wave_t            launch_r, launch_nxt;
  out_rsp_t         out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CAP_W-1:0] cap_r;
  logic             cfg_write;
  logic [CW-1:0]    cap_ext, eff_cap, last_c;
  logic [IDX_W-1:0] last_idx;
  wave_t            chain [MAX_ENTRIES+1];
  wave_t            tail;
  logic [MAX_ENTRIES:0] chain_active;

  // clamp capacity into 1..MAX_ENTRIES and find the last cell in use
  assign cap_ext  = CW'(cap_r);
  assign eff_cap  = (cap_ext == '0) ? CW'(1) :
                    (cap_ext > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : cap_ext;
  assign last_c   = eff_cap - CW'(1);
  assign last_idx = last_c[IDX_W-1:0];

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_write = cfg_valid && cfg_ready;

  assign chain[0] = launch_r;
  assign tail     = chain[MAX_ENTRIES];

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      lkv_cell #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .INDEX      (gi)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cfg_write),
        .last_idx(last_idx),
        .wave_in (chain[gi]),
        .wave_out(chain[gi+1])
      );
    end
    for (gi = 0; gi <= MAX_ENTRIES; gi++) begin : g_act
      assign chain_active[gi] = chain[gi].active;
    end
  endgenerate

  always_comb begin
    state_nxt         = state_r;
    launch_nxt        = launch_r;
    launch_nxt.active = 1'b0;
    out_nxt           = out_r;
    out_valid_nxt     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          // launch the request: a put writes on its way down, a get only looks
          launch_nxt.active    = 1'b1;
          launch_nxt.mode      = in_req.command ? MODE_WRITE : MODE_SEARCH;
          launch_nxt.key       = in_req.key;
          launch_nxt.carry_key = in_req.key;
          launch_nxt.carry_val = in_req.value;
          launch_nxt.done      = 1'b0;
          launch_nxt.hit       = 1'b0;
          launch_nxt.rd        = '0;
          launch_nxt.ev        = 1'b0;
          launch_nxt.evk       = '0;
          state_nxt            = ST_WALK;
        end
      end
      ST_WALK: begin
        if (tail.active) begin
          out_valid_nxt       = 1'b1;
          out_nxt.hit         = tail.hit;
          out_nxt.read_value  = tail.rd;
          out_nxt.evicted     = tail.ev;
          out_nxt.evicted_key = tail.evk;
          if ((tail.mode == MODE_SEARCH) && tail.hit) begin
            // get hit: walk again to move the entry to the front
            launch_nxt.active    = 1'b1;
            launch_nxt.mode      = MODE_WRITE;
            launch_nxt.key       = tail.key;
            launch_nxt.carry_key = tail.key;
            launch_nxt.carry_val = tail.rd;
            launch_nxt.done      = 1'b0;
            launch_nxt.hit       = 1'b0;
            launch_nxt.rd        = '0;
            launch_nxt.ev        = 1'b0;
            launch_nxt.evk       = '0;
            state_nxt            = ST_MOVE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MOVE: begin
        // drop the second walk's result: it was reported after the search
        if (tail.active) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= '0;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // at most one request token anywhere in the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_active))
    else $error("more than one request in the chain");

  // results come only from the end of a first walk
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_WALK))
    else $error("result outside a walk");

  // an eviction never goes with a hit
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.evicted) |-> !out_r.hit)
    else $error("eviction reported on a hit");

  // a miss returns no value
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.hit) |-> (out_r.read_value == '0))
    else $error("value returned on a miss");

endmodule
